/* sv/text_console_cursor_engine_top_macros.svh */
// assertion macros shared by the text console cursor engine modules
// no dependencies; included by every file that carries assertions
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCCE_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TCCE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tcce_pkg.sv */
// shared types, widths and codes of the text console cursor engine
// no dependencies; used by every module of the block
package tcce_pkg;

  localparam int CHAR_W = 8;
  localparam int POS_W  = 12;
  localparam int COL_W  = 9;
  localparam int INK_W  = 32;
  localparam int ACC_W  = 24;
  localparam int DC_W   = 3;
  localparam int CFG_W  = 12;
  localparam int CIDX_W = 2;

  // reset values of the configuration registers and the ink
  localparam logic [COL_W-1:0]  LAST_COLUMN_RST   = 9'd99;
  localparam logic [POS_W-1:0]  SCREEN_HEIGHT_RST = 12'd600;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE_RST  = 8'd10;
  localparam logic [CHAR_W-1:0] ESCAPE_CODE_RST   = 8'd27;
  localparam logic [INK_W-1:0]  INK_RST           = 32'hFFFF_FFFF;

  // index of the final hex digit of a color escape
  localparam logic [DC_W-1:0] DIGIT_LAST = 3'd5;

  // ascii codes for hex digits
  localparam logic [CHAR_W-1:0] ASC_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] ASC_DIGIT_9 = 8'h39;
  localparam logic [CHAR_W-1:0] ASC_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASC_UPPER_F = 8'h46;
  localparam logic [CHAR_W-1:0] ASC_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASC_LOWER_F = 8'h66;
  localparam logic [CHAR_W-1:0] HEX_TEN     = 8'd10;

  // command kinds on the result channel
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    CFG_LAST_COLUMN   = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_NEWLINE_CODE  = 2'd2,
    CFG_ESCAPE_CODE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COL_W-1:0]  last_column;
    logic [POS_W-1:0]  screen_height;
    logic [CHAR_W-1:0] newline_code;
    logic [CHAR_W-1:0] escape_code;
  } cfg_t;

  // one queue entry: an optional scroll followed by an optional glyph
  typedef struct packed {
    logic              has_scroll;
    logic [POS_W-1:0]  rows;
    logic              has_glyph;
    logic [CHAR_W-1:0] glyph;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [INK_W-1:0]  ink;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // case-insensitive hex digit decode
  function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_t r;
    r = '0;
    case (c) inside
      [ASC_DIGIT_0:ASC_DIGIT_9]: begin
        r.ok  = 1'b1;
        r.val = 4'(c - ASC_DIGIT_0);
      end
      [ASC_UPPER_A:ASC_UPPER_F]: begin
        r.ok  = 1'b1;
        r.val = 4'(c - ASC_UPPER_A + HEX_TEN);
      end
      [ASC_LOWER_A:ASC_LOWER_F]: begin
        r.ok  = 1'b1;
        r.val = 4'(c - ASC_LOWER_A + HEX_TEN);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/tcce_front.sv */
// front end: takes character beats, runs the escape parser and cursor
// uses tcce_pkg; pushes one command entry per printing or scrolling char
module tcce_front #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_WIDTH  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tcce_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcce_pkg::CHAR_W-1:0]  char_code,
  input  logic                         q_full,
  output logic                         push,
  output tcce_pkg::entry_t             push_data
);

  localparam int POS_W = tcce_pkg::POS_W;
  localparam int SUM_W = POS_W + 2;
  localparam int LIM_W = tcce_pkg::COL_W + $clog2(GLYPH_WIDTH + 1);
  localparam logic [SUM_W-1:0] GH_S = SUM_W'(GLYPH_HEIGHT);
  localparam logic [POS_W-1:0] GH_P = POS_W'(GLYPH_HEIGHT);
  localparam logic [POS_W-1:0] GW_P = POS_W'(GLYPH_WIDTH);
  localparam logic [LIM_W-1:0] GW_L = LIM_W'(GLYPH_WIDTH);

  logic [tcce_pkg::DC_W-1:0]  digit_count;
  logic [tcce_pkg::ACC_W-1:0] color_accum;
  logic [tcce_pkg::INK_W-1:0] ink_color;
  logic [POS_W-1:0]           cursor_x;
  logic [POS_W-1:0]           cursor_y;

  logic                       accept;
  tcce_pkg::hex_t             hex;
  logic                       in_escape;
  logic                       digit_path, esc_path, nl_path, print_path;
  logic [tcce_pkg::DC_W-1:0]  pos;
  logic [4:0]                 shamt;
  logic [tcce_pkg::ACC_W-1:0] accum_next;
  logic [LIM_W-1:0]           col_lim;
  logic                       col_fits;
  logic [POS_W-1:0]           x_adv;
  logic [SUM_W-1:0]           new_y, need, sh_s, up;
  logic                       do_scroll;
  logic [POS_W-1:0]           rows, y_clamp, settled_y;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // classify the character
  assign hex        = tcce_pkg::hex_decode(char_code);
  assign in_escape  = digit_count != '0;
  assign digit_path = in_escape && hex.ok;
  assign nl_path    = !in_escape && (char_code == cfg.newline_code);
  assign esc_path   = !in_escape && (char_code != cfg.newline_code)
                      && (char_code == cfg.escape_code);
  assign print_path = (in_escape && !hex.ok)
                      || (!in_escape && (char_code != cfg.newline_code)
                          && (char_code != cfg.escape_code));

  // hex digit insert, most significant nibble first
  assign pos        = digit_count - tcce_pkg::DC_W'(1);
  assign shamt      = {tcce_pkg::DIGIT_LAST - pos, 2'b00};
  assign accum_next = color_accum | (tcce_pkg::ACC_W'(hex.val) << shamt);

  // column advance: x / width < last_column  <=>  x < last_column * width
  assign col_lim  = LIM_W'(cfg.last_column) * GW_L;
  assign col_fits = LIM_W'(cursor_x) < col_lim;
  assign x_adv    = col_fits ? cursor_x + GW_P : '0;

  // next row and scroll check
  always_comb begin
    if (nl_path || !col_fits) begin
      new_y = SUM_W'(cursor_y) + GH_S;
    end else begin
      new_y = SUM_W'(cursor_y);
    end
  end

  assign need      = new_y + GH_S;
  assign sh_s      = SUM_W'(cfg.screen_height);
  assign do_scroll = sh_s < need;
  assign up        = need - sh_s;
  assign rows      = (|up[SUM_W-1:POS_W]) ? '1 : up[POS_W-1:0];
  assign y_clamp   = (cfg.screen_height >= GH_P) ? cfg.screen_height - GH_P : '0;
  assign settled_y = do_scroll ? y_clamp : new_y[POS_W-1:0];

  // entry toward the back end
  assign push = accept && (print_path || (nl_path && do_scroll));

  always_comb begin
    push_data            = '0;
    push_data.has_scroll = do_scroll;
    push_data.rows       = rows;
    push_data.has_glyph  = print_path;
    push_data.glyph      = char_code;
    push_data.x          = x_adv;
    push_data.y          = settled_y;
    push_data.ink        = ink_color;
  end

  // parser and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
      color_accum <= '0;
      ink_color   <= tcce_pkg::INK_RST;
      cursor_x    <= '0;
      cursor_y    <= '0;
    end else if (accept) begin
      if (digit_path) begin
        color_accum <= accum_next;
        if (pos == tcce_pkg::DIGIT_LAST) begin
          ink_color   <= tcce_pkg::INK_W'(accum_next);
          digit_count <= '0;
        end else begin
          digit_count <= digit_count + tcce_pkg::DC_W'(1);
        end
      end
      if (esc_path) begin
        digit_count <= tcce_pkg::DC_W'(1);
        color_accum <= '0;
      end
      if (nl_path) begin
        cursor_x <= '0;
        cursor_y <= settled_y;
      end
      if (print_path) begin
        digit_count <= '0;
        cursor_x    <= x_adv;
        cursor_y    <= settled_y;
      end
    end
  end

endmodule

/* sv/tcce_queue.sv */
// small command queue between the front and back ends
// uses tcce_pkg entry type and the shared assertion macros
`include "text_console_cursor_engine_top_macros.svh"

module tcce_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tcce_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output tcce_pkg::entry_t pop_data,
  output logic             not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  tcce_pkg::entry_t   mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `TCCE_ASSERT_NOW(a_no_push_full, clk, rst, push, !full, "push into full queue")
  `TCCE_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, not_empty, "pop from empty queue")
  `TCCE_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "count overrun")

endmodule

/* sv/tcce_back.sv */
// back end: expands queue entries into scroll and draw command beats
// uses tcce_pkg and the shared assertion macros; holds the output register
`include "text_console_cursor_engine_top_macros.svh"

module tcce_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  tcce_pkg::entry_t             q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         kind,
  output logic [tcce_pkg::CHAR_W-1:0]  glyph,
  output logic [tcce_pkg::POS_W-1:0]   pos_x,
  output logic [tcce_pkg::POS_W-1:0]   pos_y,
  output logic [tcce_pkg::INK_W-1:0]   ink,
  output logic [tcce_pkg::POS_W-1:0]   scroll_rows,
  output logic                         last
);

  tcce_pkg::entry_t cur;
  logic             cur_valid;
  logic             scroll_sent;
  logic             show_scroll;
  logic             out_take;
  logic             split;
  logic             advance;

  assign show_scroll = cur.has_scroll && !scroll_sent;
  assign out_take    = cur_valid && !out_stall;
  assign split       = show_scroll && cur.has_glyph;
  assign advance     = !cur_valid || (out_take && !split);
  assign q_pop       = advance && q_valid;

  // current entry and the scroll-done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid   <= 1'b0;
      scroll_sent <= 1'b0;
    end else if (advance) begin
      cur_valid   <= q_valid;
      scroll_sent <= 1'b0;
    end else if (out_take && split) begin
      scroll_sent <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_valid) begin
      cur <= q_data;
    end
  end

  // output beat fields
  always_comb begin
    out_valid = cur_valid;
    if (show_scroll) begin
      kind        = tcce_pkg::KIND_SCROLL;
      glyph       = '0;
      pos_x       = '0;
      pos_y       = '0;
      ink         = '0;
      scroll_rows = cur.rows;
      last        = !cur.has_glyph;
    end else begin
      kind        = tcce_pkg::KIND_DRAW;
      glyph       = cur.glyph;
      pos_x       = cur.x;
      pos_y       = cur.y;
      ink         = cur.ink;
      scroll_rows = '0;
      last        = 1'b1;
    end
  end

  `TCCE_ASSERT_NOW(a_sent_needs_pair, clk, rst, scroll_sent,
    cur_valid && cur.has_scroll && cur.has_glyph, "scroll flag without a pair")
  `TCCE_ASSERT_NEXT(a_draw_follows, clk, rst, out_take && split,
    out_valid && (kind == tcce_pkg::KIND_DRAW), "draw beat missing after scroll")
  `TCCE_ASSERT_NOW(a_pop_when_free, clk, rst, q_pop,
    !cur_valid || (out_take && !split), "pop while holding an unsent beat")

endmodule

/* sv/text_console_cursor_engine_top.sv */
// Text console cursor engine. Input channel: one character byte per beat
// (in_valid / in_stall / char_code). Output channel: draw glyph or scroll
// commands (out_valid / out_stall / kind, glyph, pos_x, pos_y, ink,
// scroll_rows, last); last marks the final command of a character.
// Config: cfg_write with cfg_index 0 last_column, 1 screen_height,
// 2 newline_code, 3 escape_code, value on cfg_data; write only when idle.
// Throughput: one character per cycle while the queue is not full; a character
// that scrolls and draws gives two output beats, a newline that scrolls gives
// one, and other newlines, escapes and hex digits give none.
// Path: the front end writes each command entry into the queue at the beat
// edge, the back end loads it into its output register once that register is
// free, and the command is offered from that register.
// A queue of QUEUE_DEPTH entries sits between them; in_stall rises only
// when that queue is full, so an output stall backs up into the input
// after QUEUE_DEPTH + 1 pending command entries. A stalled beat holds steady.
// Reset (rst, synchronous): config to defaults, cursor home, ink white,
// escape parse off, queue and output register empty.
// Depends on tcce_pkg, tcce_front, tcce_queue and tcce_back.
module text_console_cursor_engine_top #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_WIDTH  = 8,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tcce_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tcce_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [tcce_pkg::CHAR_W-1:0]   glyph,
  output logic [tcce_pkg::POS_W-1:0]    pos_x,
  output logic [tcce_pkg::POS_W-1:0]    pos_y,
  output logic [tcce_pkg::INK_W-1:0]    ink,
  output logic [tcce_pkg::POS_W-1:0]    scroll_rows,
  output logic                          last
);

  tcce_pkg::cfg_t   cfg;
  tcce_pkg::entry_t push_data, pop_data;
  logic             push, pop, q_full, q_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.last_column   <= tcce_pkg::LAST_COLUMN_RST;
      cfg.screen_height <= tcce_pkg::SCREEN_HEIGHT_RST;
      cfg.newline_code  <= tcce_pkg::NEWLINE_CODE_RST;
      cfg.escape_code   <= tcce_pkg::ESCAPE_CODE_RST;
    end else if (cfg_write) begin
      unique case (tcce_pkg::cfg_reg_t'(cfg_index))
        tcce_pkg::CFG_LAST_COLUMN:   cfg.last_column   <= cfg_data[tcce_pkg::COL_W-1:0];
        tcce_pkg::CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[tcce_pkg::POS_W-1:0];
        tcce_pkg::CFG_NEWLINE_CODE:  cfg.newline_code  <= cfg_data[tcce_pkg::CHAR_W-1:0];
        tcce_pkg::CFG_ESCAPE_CODE:   cfg.escape_code   <= cfg_data[tcce_pkg::CHAR_W-1:0];
        default: cfg <= cfg;
      endcase
    end
  end

  // parser and cursor
  tcce_front #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .GLYPH_WIDTH  (GLYPH_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // command queue
  tcce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  // command output
  tcce_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (pop_data),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .glyph       (glyph),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .ink         (ink),
    .scroll_rows (scroll_rows),
    .last        (last)
  );

endmodule

/* bench/tb.sv */
// testbench for text_console_cursor_engine_top: character beats in, draw and scroll beats out
// a model of cursor, ink and escape parsing predicts the command beats, except on directed rows that give their own
// depends on tcce_pkg and text_console_cursor_engine_top
module tb;

  localparam int unsigned GLYPH_H        = 16;
  localparam int unsigned GLYPH_W        = 8;
  localparam int          HEX_DIGITS     = 6;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic                        kind;
    logic [tcce_pkg::CHAR_W-1:0] glyph;
    logic [tcce_pkg::POS_W-1:0]  pos_x;
    logic [tcce_pkg::POS_W-1:0]  pos_y;
    logic [tcce_pkg::INK_W-1:0]  ink;
    logic [tcce_pkg::POS_W-1:0]  scroll_rows;
    logic                        last;
  } console_cmd_t;

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           what;
    tcce_pkg::cfg_reg_t  reg_idx;
    logic [11:0]         value;
    logic [7:0]          code;
    logic                typed;
    console_cmd_t        want;
  } dir_row_t;

  localparam console_cmd_t NO_CMD = '0;

  // block ports
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  tcce_pkg::cfg_reg_t            cfg_index = tcce_pkg::CFG_LAST_COLUMN;
  logic [tcce_pkg::CFG_W-1:0]    cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [tcce_pkg::CHAR_W-1:0]   char_code = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          kind;
  logic [tcce_pkg::CHAR_W-1:0]   glyph;
  logic [tcce_pkg::POS_W-1:0]    pos_x;
  logic [tcce_pkg::POS_W-1:0]    pos_y;
  logic [tcce_pkg::INK_W-1:0]    ink;
  logic [tcce_pkg::POS_W-1:0]    scroll_rows;
  logic                          last;

  // console state as the predictor sees it
  logic [tcce_pkg::COL_W-1:0]    last_col   = tcce_pkg::LAST_COLUMN_RST;
  logic [tcce_pkg::POS_W-1:0]    scr_height = tcce_pkg::SCREEN_HEIGHT_RST;
  logic [tcce_pkg::CHAR_W-1:0]   nl_code    = tcce_pkg::NEWLINE_CODE_RST;
  logic [tcce_pkg::CHAR_W-1:0]   esc_code   = tcce_pkg::ESCAPE_CODE_RST;
  logic [2:0]                    digits     = '0;
  logic [tcce_pkg::ACC_W-1:0]    accum      = '0;
  logic [tcce_pkg::INK_W-1:0]    ink_color  = tcce_pkg::INK_RST;
  logic [tcce_pkg::POS_W-1:0]    cur_x      = '0;
  logic [tcce_pkg::POS_W-1:0]    cur_y      = '0;

  console_cmd_t        pending_cmds [$];
  console_cmd_t        head_cmd;
  int                  mismatches  = 0;
  int                  idle_cycles = 0;
  bit                  hold_output = 1'b0;
  bit                  steady_flow = 1'b0;
  dir_row_t            directed_rows [27];

  text_console_cursor_engine_top uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .char_code(char_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .glyph(glyph), .pos_x(pos_x), .pos_y(pos_y),
    .ink(ink), .scroll_rows(scroll_rows), .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // -1 for anything that is not a hex digit
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // move the cursor row, clamping at the screen bottom; true when a scroll is due
  function automatic bit place_row(input int unsigned next_y,
                                   output logic [tcce_pkg::POS_W-1:0] rows);
    int unsigned need;
    need = next_y + GLYPH_H;
    rows = '0;
    if (need > scr_height) begin
      rows  = (need - scr_height > 4095) ? 12'hFFF : 12'(need - scr_height);
      cur_y = (scr_height >= GLYPH_H) ? 12'(scr_height - GLYPH_H) : '0;
      return 1'b1;
    end
    cur_y = 12'(next_y);
    return 1'b0;
  endfunction

  // advance one cell, wrapping after the last column, then draw there
  function automatic int print_cell(input logic [7:0] c, output console_cmd_t res [2]);
    int unsigned                 next_y;
    logic [tcce_pkg::POS_W-1:0]  rows;
    int                          n;
    n = 0;
    res[0] = NO_CMD;
    res[1] = NO_CMD;
    next_y = 32'(cur_y);
    if (cur_x / GLYPH_W < last_col) begin
      cur_x = cur_x + 12'(GLYPH_W);
    end else begin
      cur_x  = '0;
      next_y = cur_y + GLYPH_H;
    end
    if (place_row(next_y, rows)) begin
      res[n] = '{tcce_pkg::KIND_SCROLL, 8'd0, 12'd0, 12'd0, 32'd0, rows, 1'b0};
      n++;
    end
    res[n] = '{tcce_pkg::KIND_DRAW, c, cur_x, cur_y, ink_color, 12'd0, 1'b1};
    return n + 1;
  endfunction

  // commands caused by one character
  function automatic int console_step(input logic [7:0] c, output console_cmd_t res [2]);
    int                          nib;
    logic [tcce_pkg::POS_W-1:0]  rows;
    res[0] = NO_CMD;
    res[1] = NO_CMD;
    if (digits != 0) begin
      nib = hex_nibble(c);
      if (nib < 0) begin
        digits = '0;
        return print_cell(c, res);
      end
      accum = accum | (24'(nib) << (4 * (HEX_DIGITS - digits)));
      if (digits == HEX_DIGITS) begin
        ink_color = {8'h00, accum};
        digits    = '0;
      end else begin
        digits = digits + 3'd1;
      end
      return 0;
    end
    if (c == nl_code) begin
      cur_x = '0;
      if (place_row(cur_y + GLYPH_H, rows)) begin
        res[0] = '{tcce_pkg::KIND_SCROLL, 8'd0, 12'd0, 12'd0, 32'd0, rows, 1'b1};
        return 1;
      end
      return 0;
    end
    if (c == esc_code) begin
      digits = 3'd1;
      accum  = '0;
      return 0;
    end
    return print_cell(c, res);
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // offer one character beat and queue what it should produce
  task automatic send_char(input logic [7:0] c, input logic typed, input console_cmd_t want);
    console_cmd_t res [2];
    int           n;
    int           g;
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (in_stall);
    n = console_step(c, res);
    if (typed) begin
      pending_cmds.push_back(want);
    end else begin
      for (int k = 0; k < n; k++) pending_cmds.push_back(res[k]);
    end
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // stop sending and let every pending command drain
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input tcce_pkg::cfg_reg_t idx,
                           input logic [tcce_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      tcce_pkg::CFG_LAST_COLUMN:   last_col   = val[tcce_pkg::COL_W-1:0];
      tcce_pkg::CFG_SCREEN_HEIGHT: scr_height = val;
      tcce_pkg::CFG_NEWLINE_CODE:  nl_code    = val[tcce_pkg::CHAR_W-1:0];
      tcce_pkg::CFG_ESCAPE_CODE:   esc_code   = val[tcce_pkg::CHAR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [tcce_pkg::COL_W-1:0] lc,
                            input logic [tcce_pkg::POS_W-1:0] sh,
                            input logic [tcce_pkg::CHAR_W-1:0] nl,
                            input logic [tcce_pkg::CHAR_W-1:0] esc);
    quiesce();
    write_reg(tcce_pkg::CFG_LAST_COLUMN, 12'(lc));
    write_reg(tcce_pkg::CFG_SCREEN_HEIGHT, sh);
    write_reg(tcce_pkg::CFG_NEWLINE_CODE, 12'(nl));
    write_reg(tcce_pkg::CFG_ESCAPE_CODE, 12'(esc));
    cfg_write <= 1'b0;
  endtask

  // random text: newlines, color escapes (some broken off) and arbitrary bytes
  task automatic feed_phase(input int count, input int nl_pct, input int esc_pct);
    int         sent;
    int         pick;
    int         nib;
    logic [7:0] c;
    sent = 0;
    while (sent < count) begin
      pick = int'($urandom_range(0, 99));
      if (pick < nl_pct) begin
        send_char(nl_code, 1'b0, NO_CMD);
        sent++;
      end else if (pick < nl_pct + esc_pct) begin
        send_char(esc_code, 1'b0, NO_CMD);
        sent++;
        for (int d = 0; d < HEX_DIGITS; d++) begin
          if ($urandom_range(0, 24) == 0) begin
            do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
            send_char(c, 1'b0, NO_CMD);
            sent++;
            break;
          end
          nib = int'($urandom_range(0, 15));
          c = (nib < 10) ? 8'("0" + nib) : 8'(($urandom_range(0, 1) ? "a" : "A") + nib - 10);
          send_char(c, 1'b0, NO_CMD);
          sent++;
        end
      end else begin
        send_char(8'($urandom_range(0, 255)), 1'b0, NO_CMD);
        sent++;
      end
    end
  endtask

  // result side: random stalls, and one long hold-off on request
  initial begin
    int stall_len;
    int flow_len;
    forever begin
      if (hold_output) begin
        stall_len   = HOLD_CYCLES;
        hold_output = 1'b0;
      end else begin
        stall_len = pick_gap();
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      flow_len = int'($urandom_range(1, 6));
      repeat (flow_len) @(posedge clk);
    end
  end

  // compare each command beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        $error("command beat with nothing pending: kind %0d glyph %0h", kind, glyph);
        mismatches++;
      end else begin
        head_cmd = pending_cmds.pop_front();
        check_field("kind", 32'(head_cmd.kind), 32'(kind));
        check_field("glyph", 32'(head_cmd.glyph), 32'(glyph));
        check_field("pos_x", 32'(head_cmd.pos_x), 32'(pos_x));
        check_field("pos_y", 32'(head_cmd.pos_y), 32'(pos_y));
        check_field("ink", head_cmd.ink, ink);
        check_field("scroll_rows", 32'(head_cmd.scroll_rows), 32'(scroll_rows));
        check_field("last", 32'(head_cmd.last), 32'(last));
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no progress, %0d commands still pending", pending_cmds.size());
      $display("text_console_cursor_engine_top regression: fail");
      $finish;
    end
  end

  initial begin
    logic [tcce_pkg::CHAR_W-1:0] shared;
    directed_rows = '{
      // first glyphs after reset, code extremes, white ink
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h41, 1'b1,
        '{tcce_pkg::KIND_DRAW, 8'h41, 12'd8, 12'd0, tcce_pkg::INK_RST, 12'd0, 1'b1}},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h00, 1'b1,
        '{tcce_pkg::KIND_DRAW, 8'h00, 12'd16, 12'd0, tcce_pkg::INK_RST, 12'd0, 1'b1}},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'hFF, 1'b1,
        '{tcce_pkg::KIND_DRAW, 8'hFF, 12'd24, 12'd0, tcce_pkg::INK_RST, 12'd0, 1'b1}},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, tcce_pkg::NEWLINE_CODE_RST, 1'b0, NO_CMD},
      // color escape using both cases and the digit range ends
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, tcce_pkg::ESCAPE_CODE_RST, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h30, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h46, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h61, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h39, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h66, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h41, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h78, 1'b0, NO_CMD},
      // bad digit, then newline and escape codes inside an escape
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, tcce_pkg::ESCAPE_CODE_RST, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h66, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h47, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, tcce_pkg::ESCAPE_CODE_RST, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, tcce_pkg::NEWLINE_CODE_RST, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, tcce_pkg::ESCAPE_CODE_RST, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, tcce_pkg::ESCAPE_CODE_RST, 1'b0, NO_CMD},
      // one-line screen: newline scrolls
      '{ROW_CFG, tcce_pkg::CFG_SCREEN_HEIGHT, 12'd16, 8'h00, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, tcce_pkg::NEWLINE_CODE_RST, 1'b1,
        '{tcce_pkg::KIND_SCROLL, 8'h00, 12'd0, 12'd0, 32'd0, 12'd32, 1'b1}},
      // screen smaller than a glyph
      '{ROW_CFG, tcce_pkg::CFG_SCREEN_HEIGHT, 12'd0, 8'h00, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, tcce_pkg::NEWLINE_CODE_RST, 1'b0, NO_CMD},
      // single column: every glyph wraps, scroll then draw
      '{ROW_CFG, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h00, 1'b0, NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, 8'h5A, 1'b0, NO_CMD},
      // escape code equal to newline code: newline wins
      '{ROW_CFG, tcce_pkg::CFG_ESCAPE_CODE, 12'(tcce_pkg::NEWLINE_CODE_RST), 8'h00, 1'b0,
        NO_CMD},
      '{ROW_CHAR, tcce_pkg::CFG_LAST_COLUMN, 12'd0, tcce_pkg::NEWLINE_CODE_RST, 1'b0, NO_CMD}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].what == ROW_CFG) begin
        quiesce();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
        cfg_write <= 1'b0;
      end else begin
        send_char(directed_rows[i].code, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // default settings
    set_config(tcce_pkg::LAST_COLUMN_RST, tcce_pkg::SCREEN_HEIGHT_RST,
               tcce_pkg::NEWLINE_CODE_RST, tcce_pkg::ESCAPE_CODE_RST);
    feed_phase(100, 8, 10);

    // long receiver hold-off while characters keep coming
    set_config(9'($urandom_range(0, 511)), 12'($urandom_range(16, 4095)),
               tcce_pkg::NEWLINE_CODE_RST, tcce_pkg::ESCAPE_CODE_RST);
    hold_output = 1'b1;
    feed_phase(60, 10, 10);

    // one column on a full-height screen walks the cursor to the bottom
    set_config(9'd0, 12'd4095, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    feed_phase(300, 30, 2);

    // screen shrinks to nothing with the cursor at the bottom: scroll saturates
    set_config(9'd0, 12'd0, nl_code, esc_code);
    send_char(nl_code, 1'b0, NO_CMD);
    feed_phase(40, 15, 10);

    // same code for newline and escape
    shared = 8'($urandom_range(0, 255));
    set_config(9'($urandom_range(0, 511)), 12'($urandom_range(16, 4095)), shared, shared);
    feed_phase(60, 10, 10);

    // widest line, back to back beats on both sides
    steady_flow = 1'b1;
    set_config(9'd511, 12'd4095, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    feed_phase(120, 1, 3);
    steady_flow = 1'b0;

    // tiny screen with random codes
    set_config(9'($urandom_range(0, 511)), 12'($urandom_range(0, 15)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    feed_phase(50, 15, 10);

    // fully random settings
    repeat (2) begin
      set_config(9'($urandom_range(0, 511)), 12'($urandom_range(16, 4095)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      feed_phase(50, 10, 10);
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("text_console_cursor_engine_top regression: pass");
    end else begin
      $display("text_console_cursor_engine_top regression: fail");
    end
    $finish;
  end

endmodule
